>>> rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Queue geometry.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    // Fixed field widths of the request and response.
    localparam int ACT_W  = 3;
    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // Action codes carried by a request.
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_NOP        = 3'd4
    } t_action;

    // Status codes returned with a response.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_READ,
        S_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic req_ready;
        logic update;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_valid;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/deq_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one action and the word to push.
interface deq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// Response channel: queue view after the action.
interface deq_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] front_value;
    logic [31:0] rear_value;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic        is_full;
    logic [1:0]  status;

    modport source (output valid, output front_value, output rear_value,
                    output occupancy, output is_empty, output is_full,
                    output status, input ready);
    modport sink   (input valid, input front_value, input rear_value,
                    input occupancy, input is_empty, input is_full,
                    input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a request, apply it, read the ends, load the response.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.req_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_READ;
            S_READ:   n_state = S_LOAD;
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.req_ready = 1'b1;
            S_UPDATE: o_cmd.update    = 1'b1;
            S_READ:   o_cmd           = '0;
            S_LOAD:   o_cmd.load_out  = i_stat.out_free;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/deq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_dp
    import deq_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    deq_req_if.sink       i_req,
    deq_rsp_if.source     o_rsp
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Captured request.
    logic [ACT_W-1:0]  r_action;
    logic [WORD_W-1:0] r_value;

    // Queue state.
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [WORD_W-1:0] r_mem [DEPTH];

    // Memory write port.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    // Registered end reads.
    logic [IDX_W-1:0]  rear_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic [CNT_W-1:0]  rear_sum;
    logic [CNT_W-1:0]  tail_sum;
    logic [WORD_W-1:0] r_rd_front;
    logic [WORD_W-1:0] r_rd_rear;

    // Response register.
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_front;
    logic [WORD_W-1:0] r_out_rear;
    logic [OCC_W-1:0]  r_out_occ;
    logic              r_out_empty;
    logic              r_out_full;
    logic [STAT_W-1:0] r_out_status;

    logic              is_empty;
    logic              is_full;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= DEPTH_C);

    // Circular index arithmetic: the sums stay below twice the depth.
    assign rear_sum = CNT_W'(r_head) + r_count - CNT_W'(1);
    assign tail_sum = CNT_W'(r_head) + r_count;
    assign rear_idx = (rear_sum >= DEPTH_C) ? IDX_W'(rear_sum - DEPTH_C) : IDX_W'(rear_sum);
    assign tail_idx = (tail_sum >= DEPTH_C) ? IDX_W'(tail_sum - DEPTH_C) : IDX_W'(tail_sum);

    // Capture the request when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_value  <= i_req.value;
        end
    end

    // Apply the requested action to the pointers.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_idx   = tail_idx;
        case (r_action)
            ACT_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_head  = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - IDX_W'(1);
                    n_count = r_count + CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_idx  = n_head;
                end
            end
            ACT_PUSH_REAR: begin
                if (is_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    wr_en   = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_head  = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_POP_REAR: begin
                if (is_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    // Pointer and status registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_status <= n_status;
        end
    end

    // Slot storage with one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && wr_en) begin
            r_mem[wr_idx] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_front <= r_mem[r_head];
        r_rd_rear  <= r_mem[rear_idx];
    end

    // Response valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Response payload; an empty queue reports all ones at both ends.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_front  <= is_empty ? '1 : r_rd_front;
            r_out_rear   <= is_empty ? '1 : r_rd_rear;
            r_out_occ    <= OCC_W'(r_count);
            r_out_empty  <= is_empty;
            r_out_full   <= is_full;
            r_out_status <= r_status;
        end
    end

    assign i_req.ready       = i_cmd.req_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.rear_value  = r_out_rear;
    assign o_rsp.occupancy   = r_out_occ;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;
    assign o_rsp.status      = r_out_status;

    assign o_stat.req_valid = i_req.valid;
    assign o_stat.out_free  = !r_out_valid || o_rsp.ready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("element count exceeds depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || o_rsp.ready))
        else $error("response overwritten before it was taken");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (r_status != ST_PUSH_FULL || r_count == DEPTH_C))
        else $error("push rejected while queue not full");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (r_status != ST_POP_EMPTY || r_count == '0))
        else $error("pop ignored while queue not empty");
`endif

endmodule

`default_nettype wire

>>> rtl/core/double_ended_queue.sv
// The controller walks capture, pointer update, registered slot read and load, and
// takes no new request until the response register is loaded; the load waits
// while the previous response has not been taken.
// Reset is synchronous and active low: it empties the queue, clears the head
// pointer, the controller and the response valid; slot contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Pointers, slot storage and response register.
    deq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    // Action codes that the block treats as no operation.
    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    // Traffic shaping for the random part.
    localparam int N_PHASES        = 4;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int SENDER_IDLE[N_PHASES]    = '{0, 63, 0, 14};
    localparam int RECEIVER_STALL[N_PHASES] = '{0, 0, 63, 14};
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 8;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    // Queue view returned with every request.
    typedef struct packed {
        logic [WORD_W-1:0] front_value;
        logic [WORD_W-1:0] rear_value;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic              is_full;
        t_status           status;
    } t_queue_view;

    // Tracks the deque contents and matches each response with its request.
    class deque_scoreboard;
        logic [WORD_W-1:0] slots[DEPTH];
        int                head;
        int                count;
        t_queue_view       expected_views[$];
        int                failures;

        function void clear();
            head = 0;
            count = 0;
            failures = 0;
            expected_views.delete();
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        // Apply one accepted request and queue the view that must come back.
        function void note_request(logic [ACT_W-1:0] act, logic [WORD_W-1:0] word);
            t_queue_view view;
            t_status     st;
            st = ST_DONE;
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                    if (count == DEPTH) begin
                        st = ST_PUSH_FULL;
                    end else if (act == ACT_PUSH_FRONT) begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = word;
                        count++;
                    end else begin
                        slots[(head + count) % DEPTH] = word;
                        count++;
                    end
                end
                ACT_POP_FRONT, ACT_POP_REAR: begin
                    if (count == 0) begin
                        st = ST_POP_EMPTY;
                    end else begin
                        if (act == ACT_POP_FRONT) begin
                            head = (head + 1) % DEPTH;
                        end
                        count--;
                    end
                end
                default: ;
            endcase
            if (count == 0) begin
                view.front_value = '1;
                view.rear_value  = '1;
            end else begin
                view.front_value = slots[head];
                view.rear_value  = slots[(head + count - 1) % DEPTH];
            end
            view.occupancy = OCC_W'(count);
            view.is_empty  = (count == 0);
            view.is_full   = (count == DEPTH);
            view.status    = st;
            expected_views.push_back(view);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] exp_v,
                                    logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
                failures++;
            end
        endfunction

        // Compare one accepted response with the oldest expected view.
        function void check_response(t_queue_view got);
            t_queue_view want;
            if (expected_views.size() == 0) begin
                $display("%0t: response with no request outstanding, got %h", $time, got);
                failures++;
                return;
            end
            want = expected_views.pop_front();
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("rear_value", want.rear_value, got.rear_value);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;

    deque_scoreboard sb = new;

    deq_req_if req ();
    deq_rsp_if rsp ();

    double_ended_queue dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch both channels; a response always belongs to an earlier request.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req.valid && req.ready) begin
                sb.note_request(req.action, req.value);
            end
            if (rsp.valid && rsp.ready) begin
                sb.check_response('{front_value: rsp.front_value,
                                    rear_value:  rsp.rear_value,
                                    occupancy:   rsp.occupancy,
                                    is_empty:    rsp.is_empty,
                                    is_full:     rsp.is_full,
                                    status:      t_status'(rsp.status)});
            end
        end
    end

    // Response side: random stalls, plus a long hold-off whenever one is asked for.
    initial begin
        int seen_holds;
        seen_holds = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != seen_holds) begin
                seen_holds = hold_requests;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one request, with a random idle gap first; returns on a falling edge.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid  <= 1'b1;
        req.action <= act;
        req.value  <= word;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    // Mostly random words, with the corner values showing up now and then.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Pick an action whose push share depends on the current burst mode.
    function automatic logic [ACT_W-1:0] random_action(int mode);
        int push_pct;
        int r;
        push_pct = (mode == MODE_FILL) ? 78 : (mode == MODE_DRAIN) ? 22 : 50;
        r = $urandom_range(99);
        if (r < 5) begin
            return ACT_NOP + ACT_W'($urandom_range(3));
        end
        if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        end
        return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
    endfunction

    // Empty pops, spare codes, extreme words, wrap of the head, fill and overflow.
    task automatic run_directed();
        int k;
        send_request(ACT_POP_FRONT, 32'h1234_5678);
        send_request(ACT_POP_REAR, 32'h8765_4321);
        send_request(ACT_NOP, 32'hdead_beef);
        send_request(ACT_SPARE_5, 32'hffff_ffff);
        send_request(ACT_SPARE_6, 32'h0000_0000);
        send_request(ACT_SPARE_7, 32'h5555_aaaa);
        send_request(ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(ACT_PUSH_REAR, 32'h7fff_ffff);
        send_request(ACT_PUSH_FRONT, 32'hffff_ffff);
        send_request(ACT_PUSH_REAR, 32'h0000_0000);
        for (k = 4; k < DEPTH; k++) begin
            send_request((k % 2 == 0) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, $urandom);
        end
        send_request(ACT_PUSH_FRONT, 32'haaaa_5555);
        send_request(ACT_PUSH_REAR, 32'h0f0f_f0f0);
        send_request(ACT_POP_FRONT, 32'hffff_ffff);
        send_request(ACT_POP_REAR, 32'h0000_0000);
    endtask

    // Main sequence: reset, directed requests, random phases, drain and verdict.
    initial begin
        int phase;
        int item;
        int mode;
        int burst_left;
        int waited;
        sb.clear();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = 0;
        req.valid  <= 1'b0;
        req.action <= ACT_NOP;
        req.value  <= '0;
        rst_n      <= 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        mode = MODE_MIXED;
        burst_left = 0;
        for (phase = 0; phase < N_PHASES; phase++) begin
            sender_idle_pct    = SENDER_IDLE[phase];
            receiver_stall_pct = RECEIVER_STALL[phase];
            // Back up the whole block while requests keep coming.
            if (phase == 0) begin
                hold_requests++;
            end
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                if (burst_left == 0) begin
                    mode = $urandom_range(MODE_MIXED);
                    burst_left = $urandom_range(40, 8);
                end
                burst_left--;
                send_request(random_action(mode), random_word());
            end
        end
        req.valid <= 1'b0;

        // Let every outstanding response come back, then settle before the verdict.
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d responses never arrived", $time, sb.pending());
        end
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
